// ===== design/rsls_pkg.sv =====
// ----------------------------------------------------------------------------
// rsls_pkg
// Shared types and constants of the RGB status LED sequencer.
// ----------------------------------------------------------------------------
package rsls_pkg;

  // field widths
  localparam int LevelW = 7;
  localparam int ModeW  = 2;
  localparam int PhaseW = 3;
  localparam int TimeW  = 16;
  localparam int FuncW  = 2;
  localparam int IndexW = 3;
  localparam int DataW  = 16;

  // led modes
  localparam logic [ModeW-1:0] MODE_BOOT  = 2'd0;
  localparam logic [ModeW-1:0] MODE_USB   = 2'd1;
  localparam logic [ModeW-1:0] MODE_BATT  = 2'd2;
  localparam logic [ModeW-1:0] MODE_MOUSE = 2'd3;

  // item kinds
  localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_USB   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_MOUSE = 2'd2;

  // register indexes
  localparam logic [IndexW-1:0] REG_BRIGHTNESS   = 3'd0;
  localparam logic [IndexW-1:0] REG_BOOT_ON      = 3'd1;
  localparam logic [IndexW-1:0] REG_BOOT_OFF     = 3'd2;
  localparam logic [IndexW-1:0] REG_USB_ON       = 3'd3;
  localparam logic [IndexW-1:0] REG_USB_OFF      = 3'd4;
  localparam logic [IndexW-1:0] REG_BATT_INTERVAL = 3'd5;
  localparam logic [IndexW-1:0] REG_BATT_FLASH   = 3'd6;
  localparam logic [IndexW-1:0] REG_BATT_GAP     = 3'd7;

  // fixed timing and limits
  localparam logic [LevelW-1:0] LEVEL_MAX      = 7'd100;
  localparam logic [TimeW-1:0]  MOUSE_ON_TICKS  = 16'd40;
  localparam logic [TimeW-1:0]  MOUSE_OFF_TICKS = 16'd80;
  localparam logic [PhaseW-1:0] USB_PHASES      = 3'd6;
  localparam logic [PhaseW-1:0] BOOT_PHASES     = 3'd6;
  localparam logic [PhaseW-1:0] BATT_PHASES     = 3'd3;
  localparam logic [PhaseW-1:0] MOUSE_PHASES    = 3'd4;

  // configuration register file
  typedef struct packed {
    logic [LevelW-1:0] brightness;
    logic [TimeW-1:0]  boot_on_ms;
    logic [TimeW-1:0]  boot_off_ms;
    logic [TimeW-1:0]  usb_on_ms;
    logic [TimeW-1:0]  usb_off_ms;
    logic [TimeW-1:0]  batt_interval;
    logic [TimeW-1:0]  batt_flash;
    logic [TimeW-1:0]  batt_gap;
  } cfg_t;

  // sequencer state
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [PhaseW-1:0] phase;
    logic              link_up;
    logic [TimeW-1:0]  countdown;
    logic [LevelW-1:0] red_now;
    logic [LevelW-1:0] green_now;
    logic [LevelW-1:0] blue_now;
  } seq_state_t;

endpackage

// ===== design/rsls_in_if.sv =====
// ----------------------------------------------------------------------------
// rsls_in_if
// Input channel: one tick, USB event or mouse toggle per beat.
// ----------------------------------------------------------------------------
interface rsls_in_if;
  logic                       valid;
  logic                       ready;
  logic [rsls_pkg::FuncW-1:0] func;
  logic                       usb_hid;

  modport source (output valid, output func, output usb_hid, input ready);
  modport sink (input valid, input func, input usb_hid, output ready);
endinterface

// ===== design/rsls_out_if.sv =====
// ----------------------------------------------------------------------------
// rsls_out_if
// Result channel: colour levels and led mode, one beat per input beat.
// ----------------------------------------------------------------------------
interface rsls_out_if;
  logic                        valid;
  logic                        ready;
  logic [rsls_pkg::LevelW-1:0] red_level;
  logic [rsls_pkg::LevelW-1:0] green_level;
  logic [rsls_pkg::LevelW-1:0] blue_level;
  logic [rsls_pkg::ModeW-1:0]  led_mode;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  output led_mode, input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                input led_mode, output ready);
endinterface

// ===== design/rsls_step.sv =====
// ----------------------------------------------------------------------------
// rsls_step
// Next-state logic: applies one beat (tick, USB event, mouse toggle) to the
// sequencer state.
// ----------------------------------------------------------------------------
module rsls_step (
  input  rsls_pkg::seq_state_t     cur,
  input  rsls_pkg::cfg_t           cfg,
  input  logic [rsls_pkg::FuncW-1:0] func,
  input  logic                     usb_hid,
  output rsls_pkg::seq_state_t     nxt
);
  import rsls_pkg::*;

  logic [LevelW-1:0] lvl;
  logic [PhaseW-1:0] usb_p;
  logic [PhaseW-1:0] usb_np;
  logic [PhaseW-1:0] inc_p;
  seq_state_t        usb_start;
  seq_state_t        batt_start;
  seq_state_t        resume;

  // saturated lit level, phase helpers
  assign lvl    = (cfg.brightness > LEVEL_MAX) ? LEVEL_MAX : cfg.brightness;
  assign usb_p  = (cur.phase >= USB_PHASES) ? cur.phase - USB_PHASES : cur.phase;
  assign usb_np = (usb_p == USB_PHASES - 3'd1) ? '0 : usb_p + 3'd1;
  assign inc_p  = cur.phase + 3'd1;

  // mode entry states
  always_comb begin
    usb_start           = cur;
    usb_start.mode      = MODE_USB;
    usb_start.phase     = '0;
    usb_start.countdown = '0;

    batt_start           = cur;
    batt_start.mode      = MODE_BATT;
    batt_start.phase     = '0;
    batt_start.red_now   = '0;
    batt_start.green_now = '0;
    batt_start.blue_now  = '0;
    batt_start.countdown = cfg.batt_interval;

    resume = cur.link_up ? usb_start : batt_start;
  end

  // apply one beat
  always_comb begin
    nxt = cur;
    case (func)
      FUNC_TICK: begin
        if (cur.countdown > 16'd1) begin
          nxt.countdown = cur.countdown - 16'd1;
        end else begin
          case (cur.mode)
            MODE_BOOT: begin
              if (cur.phase >= BOOT_PHASES) begin
                nxt = resume;
              end else begin
                nxt.red_now   = (cur.phase == 3'd0) ? lvl : '0;
                nxt.green_now = (cur.phase == 3'd2) ? lvl : '0;
                nxt.blue_now  = (cur.phase == 3'd4) ? lvl : '0;
                nxt.phase     = inc_p;
                nxt.countdown = inc_p[0] ? cfg.boot_on_ms : cfg.boot_off_ms;
              end
            end
            MODE_USB: begin
              nxt.red_now   = (usb_p == 3'd0) ? lvl : '0;
              nxt.green_now = (usb_p == 3'd2) ? lvl : '0;
              nxt.blue_now  = (usb_p == 3'd4) ? lvl : '0;
              nxt.phase     = usb_np;
              nxt.countdown = usb_np[0] ? cfg.usb_on_ms : cfg.usb_off_ms;
            end
            MODE_BATT: begin
              nxt.red_now   = '0;
              nxt.green_now = '0;
              if (cur.phase >= BATT_PHASES) begin
                nxt.blue_now  = '0;
                nxt.phase     = '0;
                nxt.countdown = cfg.batt_interval;
              end else begin
                nxt.blue_now  = cur.phase[0] ? '0 : lvl;
                nxt.phase     = inc_p;
                nxt.countdown = inc_p[0] ? cfg.batt_flash : cfg.batt_gap;
              end
            end
            default: begin
              if (cur.phase >= MOUSE_PHASES) begin
                nxt = resume;
              end else begin
                nxt.red_now   = '0;
                nxt.green_now = cur.phase[0] ? '0 : lvl;
                nxt.blue_now  = '0;
                nxt.phase     = inc_p;
                nxt.countdown = inc_p[0] ? MOUSE_ON_TICKS : MOUSE_OFF_TICKS;
              end
            end
          endcase
        end
      end
      FUNC_USB: begin
        // during boot only the link state is recorded
        if (cur.mode != MODE_BOOT && usb_hid && !cur.link_up) begin
          nxt = usb_start;
        end else if (cur.mode != MODE_BOOT && !usb_hid && cur.link_up) begin
          nxt = batt_start;
        end
        nxt.link_up = usb_hid;
      end
      FUNC_MOUSE: begin
        if (cur.mode != MODE_BOOT) begin
          nxt.mode      = MODE_MOUSE;
          nxt.phase     = '0;
          nxt.countdown = '0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ===== design/rgb_status_led_sequencer.sv =====
// ----------------------------------------------------------------------------
// rgb_status_led_sequencer
// RGB status LED pattern sequencer with boot, USB, battery and mouse patterns.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input beats; func 0 is a one-millisecond tick, 1 a USB state
//            event (usb_hid = 1 when linked), 2 a mouse-layer toggle.
//   result : one beat per input beat with the red, green and blue levels
//            and the led mode after that input has been applied.
//   wr_en / wr_index / wr_data : register writes; write only while idle (not enforced).
// The state and the result register load at the edge that accepts the beat,
// so its result is offered in the next cycle. Throughput is one beat per
// cycle while the receiver keeps up; the next-state logic is combinational.
// The block takes a new beat whenever the result register is empty or is
// being drained in the same cycle, so a stalled receiver holds the result
// and backs up the input after one beat.
// Reset puts the sequencer in boot mode with phase 0, link down, all levels
// dark and a zero countdown, so the first tick starts the boot flash; the
// registers return to their default timings and brightness 1.
// ----------------------------------------------------------------------------
module rgb_status_led_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  rsls_in_if.sink                       item,
  rsls_out_if.source                    result,
  input  logic                          wr_en,
  input  logic [rsls_pkg::IndexW-1:0]   wr_index,
  input  logic [rsls_pkg::DataW-1:0]    wr_data
);
  import rsls_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  logic       take;
  logic       out_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness    <= 7'd1;
      cfg.boot_on_ms    <= 16'd80;
      cfg.boot_off_ms   <= 16'd40;
      cfg.usb_on_ms     <= 16'd150;
      cfg.usb_off_ms    <= 16'd80;
      cfg.batt_interval <= 16'd5000;
      cfg.batt_flash    <= 16'd30;
      cfg.batt_gap      <= 16'd60;
    end else if (wr_en) begin
      case (wr_index)
        REG_BRIGHTNESS:    cfg.brightness    <= wr_data[LevelW-1:0];
        REG_BOOT_ON:       cfg.boot_on_ms    <= wr_data;
        REG_BOOT_OFF:      cfg.boot_off_ms   <= wr_data;
        REG_USB_ON:        cfg.usb_on_ms     <= wr_data;
        REG_USB_OFF:       cfg.usb_off_ms    <= wr_data;
        REG_BATT_INTERVAL: cfg.batt_interval <= wr_data;
        REG_BATT_FLASH:    cfg.batt_flash    <= wr_data;
        REG_BATT_GAP:      cfg.batt_gap      <= wr_data;
        default:           cfg.brightness    <= cfg.brightness;
      endcase
    end
  end

  // input handshake: free result slot or slot draining this cycle
  assign item.ready = !out_valid || result.ready;
  assign take       = item.valid && item.ready;

  // next-state logic
  rsls_step u_step (
    .cur     (state),
    .cfg     (cfg),
    .func    (item.func),
    .usb_hid (item.usb_hid),
    .nxt     (state_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.red_level   <= state_next.red_now;
      result.green_level <= state_next.green_now;
      result.blue_level  <= state_next.blue_now;
      result.led_mode    <= state_next.mode;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== sim/rgb_status_led_sequencer_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// rgb_status_led_sequencer_tb
// Self-checking bench for the status LED sequencer. An opening table walks the
// boot flash, the mode changes and the ignored items. Random phases with
// different timings and brightness follow. A local copy of the sequencer state
// predicts the levels and mode of every result beat. Both channels idle at
// random, and the result side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module rgb_status_led_sequencer_tb;
  import rsls_pkg::*;

  localparam logic [FuncW-1:0]  FUNC_UNUSED = 2'd3;
  localparam logic [LevelW-1:0] LEVEL_CAP   = 7'd100;
  localparam logic [TimeW-1:0]  BLINK_ON    = 16'd40;
  localparam logic [TimeW-1:0]  BLINK_OFF   = 16'd80;
  localparam logic [PhaseW-1:0] CYCLE_STEPS = 3'd6;
  localparam int unsigned MAX_WAIT    = 16;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [ModeW-1:0]  mode;
  } leds_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             hid;
    logic             pinned;
    leds_t            want;
  } script_row_t;

  // opening walk, run with reset brightness and short timings
  localparam int NUM_ROWS = 22;
  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    '{FUNC_USB,    1'b1, 1'b1, {7'd0, 7'd0, 7'd0, MODE_BOOT}},  // link noted in boot
    '{FUNC_MOUSE,  1'b0, 1'b1, {7'd0, 7'd0, 7'd0, MODE_BOOT}},  // mouse ignored in boot
    '{FUNC_UNUSED, 1'b1, 1'b1, {7'd0, 7'd0, 7'd0, MODE_BOOT}},  // unused code
    '{FUNC_TICK,   1'b1, 1'b1, {7'd1, 7'd0, 7'd0, MODE_BOOT}},  // red boot flash
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},                              // boot ends, link up
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_USB,    1'b1, 1'b0, '0},                              // same link again
    '{FUNC_MOUSE,  1'b1, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_MOUSE,  1'b0, 1'b0, '0},                              // restart the flash
    '{FUNC_USB,    1'b0, 1'b1, {7'd0, 7'd0, 7'd0, MODE_BATT}},  // link drops
    '{FUNC_TICK,   1'b1, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_USB,    1'b0, 1'b0, '0},
    '{FUNC_USB,    1'b1, 1'b0, '0},
    '{FUNC_TICK,   1'b0, 1'b0, '0},
    '{FUNC_UNUSED, 1'b0, 1'b0, '0}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                wr_en    = 1'b0;
  logic [IndexW-1:0]   wr_index = '0;
  logic [DataW-1:0]    wr_data  = '0;

  rsls_in_if  item_if ();
  rsls_out_if result_if ();

  rgb_status_led_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_if),
    .result   (result_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the registers and the sequencer state
  cfg_t              cfg_copy;
  logic [ModeW-1:0]  seq_mode;
  logic [PhaseW-1:0] seq_phase;
  logic              seq_link;
  logic [TimeW-1:0]  seq_count;
  logic [LevelW-1:0] lvl_red;
  logic [LevelW-1:0] lvl_green;
  logic [LevelW-1:0] lvl_blue;

  leds_t       pending_leds [$];
  int unsigned err_count = 0;
  logic        pin_on    = 1'b0;
  leds_t       pin_want  = '0;
  bit          no_idle   = 1'b0;
  bit          hold_req  = 1'b0;

  function automatic void clear_model();
    cfg_copy.brightness    = 7'd1;
    cfg_copy.boot_on_ms    = 16'd80;
    cfg_copy.boot_off_ms   = 16'd40;
    cfg_copy.usb_on_ms     = 16'd150;
    cfg_copy.usb_off_ms    = 16'd80;
    cfg_copy.batt_interval = 16'd5000;
    cfg_copy.batt_flash    = 16'd30;
    cfg_copy.batt_gap      = 16'd60;
    seq_mode  = MODE_BOOT;
    seq_phase = '0;
    seq_link  = 1'b0;
    seq_count = '0;
    lvl_red   = '0;
    lvl_green = '0;
    lvl_blue  = '0;
  endfunction

  function automatic void store_register(input logic [IndexW-1:0] idx,
                                         input logic [DataW-1:0] data);
    case (idx)
      REG_BRIGHTNESS:    cfg_copy.brightness    = data[LevelW-1:0];
      REG_BOOT_ON:       cfg_copy.boot_on_ms    = data;
      REG_BOOT_OFF:      cfg_copy.boot_off_ms   = data;
      REG_USB_ON:        cfg_copy.usb_on_ms     = data;
      REG_USB_OFF:       cfg_copy.usb_off_ms    = data;
      REG_BATT_INTERVAL: cfg_copy.batt_interval = data;
      REG_BATT_FLASH:    cfg_copy.batt_flash    = data;
      REG_BATT_GAP:      cfg_copy.batt_gap      = data;
      default: ;
    endcase
  endfunction

  // lit channels take the brightness, saturated at full scale
  function automatic void light(input logic r, input logic g, input logic b);
    logic [LevelW-1:0] lvl;
    lvl = (cfg_copy.brightness > LEVEL_CAP) ? LEVEL_CAP : cfg_copy.brightness;
    lvl_red   = r ? lvl : '0;
    lvl_green = g ? lvl : '0;
    lvl_blue  = b ? lvl : '0;
  endfunction

  function automatic void enter_usb_cycle();
    seq_mode  = MODE_USB;
    seq_phase = '0;
    seq_count = '0;
  endfunction

  function automatic void enter_battery();
    seq_mode  = MODE_BATT;
    seq_phase = '0;
    light(1'b0, 1'b0, 1'b0);
    seq_count = cfg_copy.batt_interval;
  endfunction

  function automatic void resume_pattern();
    if (seq_link) begin
      enter_usb_cycle();
    end else begin
      enter_battery();
    end
  endfunction

  // next step of the running pattern, levels and next delay
  function automatic void advance_phase();
    logic [PhaseW-1:0] p;
    case (seq_mode)
      MODE_BOOT: begin
        if (seq_phase >= 3'd6) begin
          resume_pattern();
        end else begin
          light(seq_phase == 3'd0, seq_phase == 3'd2, seq_phase == 3'd4);
          seq_phase = seq_phase + 3'd1;
          seq_count = seq_phase[0] ? cfg_copy.boot_on_ms : cfg_copy.boot_off_ms;
        end
      end
      MODE_USB: begin
        p = seq_phase % CYCLE_STEPS;
        light(p == 3'd0, p == 3'd2, p == 3'd4);
        seq_phase = (p + 3'd1) % CYCLE_STEPS;
        seq_count = seq_phase[0] ? cfg_copy.usb_on_ms : cfg_copy.usb_off_ms;
      end
      MODE_BATT: begin
        if (seq_phase >= 3'd3) begin
          light(1'b0, 1'b0, 1'b0);
          seq_phase = '0;
          seq_count = cfg_copy.batt_interval;
        end else begin
          light(1'b0, 1'b0, !seq_phase[0]);
          seq_phase = seq_phase + 3'd1;
          seq_count = seq_phase[0] ? cfg_copy.batt_flash : cfg_copy.batt_gap;
        end
      end
      default: begin
        if (seq_phase >= 3'd4) begin
          resume_pattern();
        end else begin
          light(1'b0, !seq_phase[0], 1'b0);
          seq_phase = seq_phase + 3'd1;
          seq_count = seq_phase[0] ? BLINK_ON : BLINK_OFF;
        end
      end
    endcase
  endfunction

  // apply one input beat, return the levels and mode after it
  function automatic leds_t step_sequencer(input logic [FuncW-1:0] func, input logic hid);
    logic was;
    case (func)
      FUNC_TICK: begin
        if (seq_count <= 16'd1) begin
          advance_phase();
        end else begin
          seq_count = seq_count - 16'd1;
        end
      end
      FUNC_USB: begin
        was      = seq_link;
        seq_link = hid;
        if (seq_mode != MODE_BOOT) begin
          if (seq_link && !was) begin
            enter_usb_cycle();
          end else if (!seq_link && was) begin
            enter_battery();
          end
        end
      end
      FUNC_MOUSE: begin
        if (seq_mode != MODE_BOOT) begin
          seq_mode  = MODE_MOUSE;
          seq_phase = '0;
          seq_count = '0;
        end
      end
      default: ;
    endcase
    return {lvl_red, lvl_green, lvl_blue, seq_mode};
  endfunction

  function automatic void check_field(input string name, input logic [LevelW-1:0] want,
                                      input logic [LevelW-1:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // monitor: check result beats, predict accepted item beats, track writes
  always @(posedge clk) begin
    leds_t want;
    leds_t next;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pending_leds.size() == 0) begin
          $error("result beat with no expected result waiting");
          err_count++;
        end else begin
          want = pending_leds.pop_front();
          check_field("red_level", want.red, result_if.red_level);
          check_field("green_level", want.green, result_if.green_level);
          check_field("blue_level", want.blue, result_if.blue_level);
          check_field("led_mode", LevelW'(want.mode), LevelW'(result_if.led_mode));
        end
      end
      if (item_if.valid && item_if.ready) begin
        next = step_sequencer(item_if.func, item_if.usb_hid);
        pending_leds.push_back(pin_on ? pin_want : next);
      end
      if (wr_en) begin
        store_register(wr_index, wr_data);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!(result_if.valid && result_if.ready));
      @(negedge clk);
    end
  end

  // offer one item beat after a random gap, return at the next falling edge
  task automatic send_beat(input logic [FuncW-1:0] func, input logic hid);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid   <= 1'b1;
    item_if.func    <= func;
    item_if.usb_hid <= hid;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned tick_pct);
    int unsigned pick;
    logic        hid;
    hid = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < tick_pct) begin
      send_beat(FUNC_TICK, hid);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_beat(FUNC_USB, hid);
      end else if (pick < 9) begin
        send_beat(FUNC_MOUSE, hid);
      end else begin
        send_beat(FUNC_UNUSED, hid);
      end
    end
  endtask

  // stop offering and wait for every expected result
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending_leds.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
  endtask

  task automatic write_timings(input logic [DataW-1:0] bright, input logic [DataW-1:0] b_on,
                               input logic [DataW-1:0] b_off, input logic [DataW-1:0] u_on,
                               input logic [DataW-1:0] u_off, input logic [DataW-1:0] interval,
                               input logic [DataW-1:0] flash, input logic [DataW-1:0] gap);
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_BOOT_ON, b_on);
    write_reg(REG_BOOT_OFF, b_off);
    write_reg(REG_USB_ON, u_on);
    write_reg(REG_USB_OFF, u_off);
    write_reg(REG_BATT_INTERVAL, interval);
    write_reg(REG_BATT_FLASH, flash);
    write_reg(REG_BATT_GAP, gap);
    wr_en <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] short_delay(input int unsigned top);
    return DataW'($urandom_range(0, top));
  endfunction

  // stimulus
  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned n;
    int unsigned tick_pct;
    item_if.valid   = 1'b0;
    item_if.func    = FUNC_TICK;
    item_if.usb_hid = 1'b0;
    clear_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // short timings, brightness left at its reset value
    write_reg(REG_BOOT_ON, 16'd0);
    write_reg(REG_BOOT_OFF, 16'd1);
    write_reg(REG_USB_ON, 16'd1);
    write_reg(REG_USB_OFF, 16'd2);
    write_reg(REG_BATT_INTERVAL, 16'd2);
    write_reg(REG_BATT_FLASH, 16'd1);
    write_reg(REG_BATT_GAP, 16'd1);
    wr_en <= 1'b0;

    // opening walk
    for (k = 0; k < NUM_ROWS; k++) begin
      pin_on   = SCRIPT[k].pinned;
      pin_want = SCRIPT[k].want;
      send_beat(SCRIPT[k].func, SCRIPT[k].hid);
    end
    pin_on = 1'b0;

    // random phases, each with its own timings and brightness
    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          write_timings(16'd100, short_delay(4), short_delay(4), short_delay(4),
                        short_delay(4), short_delay(4), short_delay(4), short_delay(4));
          tick_pct = 85;
        end
        1: begin
          write_timings(16'hFFFF, short_delay(3), short_delay(3), short_delay(3),
                        short_delay(3), short_delay(3), short_delay(3), short_delay(3));
          tick_pct = 90;
        end
        2: begin
          write_timings(16'd0, 16'd1, 16'd1, DataW'($urandom_range(1, 5)),
                        DataW'($urandom_range(1, 5)), DataW'($urandom_range(1, 5)),
                        DataW'($urandom_range(1, 5)), DataW'($urandom_range(1, 5)));
          tick_pct = 85;
        end
        3: begin
          write_timings(DataW'($urandom_range(0, 127)), 16'hFFFF, 16'd0, 16'hFFFF,
                        short_delay(3), 16'hFFFF, 16'd0, short_delay(3));
          tick_pct = 80;
        end
        default: begin
          write_timings(DataW'($urandom), short_delay(6), short_delay(6), short_delay(6),
                        short_delay(6), short_delay(6), short_delay(6), short_delay(6));
          tick_pct = 92;
        end
      endcase
      n = (ph == 1) ? 300 : 200;
      for (k = 0; k < n; k++) begin
        no_idle = (k % 100) >= 80;
        // long result hold-off while the input keeps offering
        if (ph == 2 && k == 40) begin
          hold_req = 1'b1;
        end
        if (ph == 2 && k >= 40 && k < 80) begin
          no_idle = 1'b1;
        end
        // pause until the pipeline is empty
        if (ph == 2 && k == 120) begin
          settle();
        end
        // full mouse flash run: one toggle, then only ticks
        if (ph == 1 && k < 260) begin
          send_beat((k == 0) ? FUNC_MOUSE : FUNC_TICK, 1'($urandom_range(0, 1)));
        end else begin
          send_random(tick_pct);
        end
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
